FILE: hw/rtl/tmm_pkg.sv
// shared widths, types and constants for the temperature tracker
`timescale 1ns / 1ps
package tmm_pkg;

    localparam int TEMP_BITS   = 16;
    localparam int COUNT_BITS  = 32;
    localparam int WEIGHT_BITS = 16;

    localparam int PROD_BITS = TEMP_BITS + COUNT_BITS + 1;
    localparam int NUM_BITS  = TEMP_BITS + COUNT_BITS + 2;
    localparam int SUM_BITS  = COUNT_BITS + 1;
    localparam int QBITS     = TEMP_BITS + 1;
    localparam int STEP_BITS = $clog2(QBITS);

    typedef logic signed [TEMP_BITS-1:0] temp_t;
    typedef logic [COUNT_BITS-1:0]       count_t;
    typedef logic [WEIGHT_BITS-1:0]      weight_t;
    typedef logic [SUM_BITS-1:0]         sum_t;
    typedef logic [NUM_BITS-1:0]         num_t;
    typedef logic [QBITS-1:0]            quot_t;

    typedef struct packed {
        logic start;
        logic neg;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: hw/rtl/tmm_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tmm_div import tmm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    input  num_t      dividend,
    input  sum_t      divisor,
    output div_stat_t stat,
    output temp_t     quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [STEP_BITS-1:0] cnt_reg, cnt_next;
    num_t                 rem_reg, rem_next;
    num_t                 dsr_reg, dsr_next;
    quot_t                q_reg, q_next;
    logic                 fits;

    assign fits = (rem_reg >= dsr_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.neg;
            cnt_next  = STEP_BITS'(QBITS - 1);
            rem_next  = dividend;
            dsr_next  = NUM_BITS'({divisor, {(QBITS-1){1'b0}}});
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            q_next   = {q_reg[QBITS-2:0], fits};
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            q_reg    <= q_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = neg_reg ? TEMP_BITS'(~q_reg + 1'b1) : TEMP_BITS'(q_reg);

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider start did not begin a run");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");

endmodule

FILE: hw/rtl/temperature_min_max_mean_tracker_core.sv
// temperature min, max and weighted mean tracker with shared multiplier and divider
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  sensor_a_temp sensor_b_temp sample_weight read_ok
//  out      output     out_valid/out_stall max_temp min_temp mean_temp sample_total halted
//
//  a tracking transaction runs from accept to result in steps: one shared
//  multiplier forms and sums the two products, ST_DIVS starts the divider,
//  which yields one quotient bit per cycle (17 bits) and then hands back the
//  quotient, and ST_OUT loads the result unless out_stall holds it; halted and
//  failed-read ones go from ST_CHECK to ST_OUT; zero total weight skips the divider
//  rst_n clears all tracking state; out_stall holds the result register, and a
//  new transaction may be accepted while a finished result still waits
`timescale 1ns / 1ps
module temperature_min_max_mean_tracker_core import tmm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  temp_t   sensor_a_temp,
    input  temp_t   sensor_b_temp,
    input  weight_t sample_weight,
    input  logic    read_ok,
    output logic    out_valid,
    input  logic    out_stall,
    output temp_t   max_temp,
    output temp_t   min_temp,
    output temp_t   mean_temp,
    output count_t  sample_total,
    output logic    halted
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL2,
        ST_ACC,
        ST_DIVS,
        ST_DIVW,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    temp_t   v_reg, v_next;
    weight_t w_reg, w_next;
    logic    ok_reg, ok_next;
    logic    upd_reg, upd_next;
    logic    mupd_reg, mupd_next;
    sum_t    sum_reg, sum_next;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic signed [NUM_BITS-1:0]  acc_reg, acc_next;
    temp_t   mean_new_reg, mean_new_next;

    temp_t   max_reg, max_next;
    temp_t   min_reg, min_next;
    temp_t   mean_reg, mean_next;
    count_t  total_reg, total_next;
    logic    stopped_reg, stopped_next;

    logic    out_valid_reg, out_valid_next;
    temp_t   out_max_reg, out_max_next;
    temp_t   out_min_reg, out_min_next;
    temp_t   out_mean_reg, out_mean_next;
    count_t  out_total_reg, out_total_next;
    logic    out_halted_reg, out_halted_next;

    logic [TEMP_BITS:0]          pair_sum;
    temp_t                       mul_a;
    count_t                      mul_b;
    logic signed [PROD_BITS-1:0] prod;
    num_t                        num_mag;
    div_req_t                    div_req;
    div_stat_t                   div_stat;
    temp_t                       div_q;

    assign pair_sum = {sensor_a_temp[TEMP_BITS-1], sensor_a_temp}
                    + {sensor_b_temp[TEMP_BITS-1], sensor_b_temp};

    always_comb
    begin
        if (state_reg == ST_CHECK)
        begin
            mul_a = mean_reg;
            mul_b = total_reg;
        end
        else
        begin
            mul_a = v_reg;
            mul_b = COUNT_BITS'(w_reg);
        end
    end

    assign prod    = mul_a * $signed({1'b0, mul_b});
    assign num_mag = acc_reg[NUM_BITS-1] ? num_t'(-acc_reg) : num_t'(acc_reg);

    assign div_req.start = (state_reg == ST_DIVS) && (sum_reg != '0);
    assign div_req.neg   = acc_reg[NUM_BITS-1];

    tmm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (num_mag),
        .divisor  (sum_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        w_next          = w_reg;
        ok_next         = ok_reg;
        upd_next        = upd_reg;
        mupd_next       = mupd_reg;
        sum_next        = sum_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        mean_new_next   = mean_new_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        mean_next       = mean_reg;
        total_next      = total_reg;
        stopped_next    = stopped_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_max_next    = out_max_reg;
        out_min_next    = out_min_reg;
        out_mean_next   = out_mean_reg;
        out_total_next  = out_total_reg;
        out_halted_next = out_halted_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    v_next     = pair_sum[TEMP_BITS:1];
                    w_next     = sample_weight;
                    ok_next    = read_ok;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                upd_next  = 1'b0;
                mupd_next = 1'b0;
                if (stopped_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (!ok_reg)
                begin
                    stopped_next = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    upd_next   = 1'b1;
                    sum_next   = SUM_BITS'(total_reg) + SUM_BITS'(w_reg);
                    prod_next  = prod;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                acc_next   = NUM_BITS'(prod_reg);
                prod_next  = prod;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next   = acc_reg + NUM_BITS'(prod_reg);
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                state_next = (sum_reg != '0) ? ST_DIVW : ST_OUT;
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    mupd_next     = 1'b1;
                    mean_new_next = div_q;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (upd_reg)
                    begin
                        if (v_reg > max_reg)
                        begin
                            max_next = v_reg;
                        end
                        if ((min_reg == '0) || (v_reg < min_reg))
                        begin
                            min_next = v_reg;
                        end
                        if (mupd_reg)
                        begin
                            mean_next = mean_new_reg;
                        end
                        total_next = sum_reg[COUNT_BITS] ? '1 : sum_reg[COUNT_BITS-1:0];
                    end
                    out_valid_next  = 1'b1;
                    out_max_next    = max_next;
                    out_min_next    = min_next;
                    out_mean_next   = mean_next;
                    out_total_next  = total_next;
                    out_halted_next = stopped_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            v_reg          <= '0;
            w_reg          <= '0;
            ok_reg         <= 1'b0;
            upd_reg        <= 1'b0;
            mupd_reg       <= 1'b0;
            sum_reg        <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            mean_new_reg   <= '0;
            max_reg        <= '0;
            min_reg        <= '0;
            mean_reg       <= '0;
            total_reg      <= '0;
            stopped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_max_reg    <= '0;
            out_min_reg    <= '0;
            out_mean_reg   <= '0;
            out_total_reg  <= '0;
            out_halted_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            v_reg          <= v_next;
            w_reg          <= w_next;
            ok_reg         <= ok_next;
            upd_reg        <= upd_next;
            mupd_reg       <= mupd_next;
            sum_reg        <= sum_next;
            prod_reg       <= prod_next;
            acc_reg        <= acc_next;
            mean_new_reg   <= mean_new_next;
            max_reg        <= max_next;
            min_reg        <= min_next;
            mean_reg       <= mean_next;
            total_reg      <= total_next;
            stopped_reg    <= stopped_next;
            out_valid_reg  <= out_valid_next;
            out_max_reg    <= out_max_next;
            out_min_reg    <= out_min_next;
            out_mean_reg   <= out_mean_next;
            out_total_reg  <= out_total_next;
            out_halted_reg <= out_halted_next;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign max_temp     = out_max_reg;
    assign min_temp     = out_min_reg;
    assign mean_temp    = out_mean_reg;
    assign sample_total = out_total_reg;
    assign halted       = out_halted_reg;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("halt flag cleared without reset");

    a_halt_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && $past(stopped_reg) |-> $stable(total_reg) && $stable(mean_reg)
            && $stable(max_reg) && $stable(min_reg))
        else $error("tracking state changed while halted");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (sum_reg != '0) && upd_reg)
        else $error("division started without an active update");

    a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output step");

endmodule
